// ===== rtl/rca_pkg.sv =====
// ----------------------------------------------------------------------------
// rca_pkg
// shared types and constants of the radix calculator
// ----------------------------------------------------------------------------
package rca_pkg;

  localparam int unsigned ACTION_W = 4;
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned OP_W     = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 4'd0,
    ACT_ADD    = 4'd1,
    ACT_SUB    = 4'd2,
    ACT_MUL    = 4'd3,
    ACT_DIV    = 4'd4,
    ACT_MOD    = 4'd5,
    ACT_RADIX  = 4'd6,
    ACT_DIGIT  = 4'd7,
    ACT_EQUAL  = 4'd8
  } action_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_t;

  localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;

  // payload of one command transfer
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DIGIT_W-1:0]  digit_value;
    logic                last_digit;
    logic [DIGIT_W-1:0]  new_radix;
  } in_item_t;

  // payload of one printed digit transfer
  typedef struct packed {
    logic [DIGIT_W-1:0] digit_out;
    logic               last_out;
    logic               error_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_MUL,
    ST_DIV,
    ST_DIV_FIX,
    ST_CONV,
    ST_CONV_STORE,
    ST_PRINT_RD,
    ST_PRINT,
    ST_ERR
  } state_t;

  // control from the sequencer to the shift-subtract divider
  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

endpackage

// ===== rtl/rca_if.sv =====
// ----------------------------------------------------------------------------
// rca_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface rca_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rca_ram.sv =====
// ----------------------------------------------------------------------------
// rca_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module rca_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/rca_div.sv =====
// ----------------------------------------------------------------------------
// rca_div
// restoring divider, one quotient bit per step, unsigned magnitudes
// ----------------------------------------------------------------------------
module rca_div
  import rca_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  div_ctl_t     ctl,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  logic [W-1:0] q_r, q_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] dvs_r;
  logic [W:0]   trial;
  logic [W:0]   diff;

  always_comb begin
    trial   = {rem_r, q_r[W-1]};
    diff    = trial - {1'b0, dvs_r};
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (ctl.start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (ctl.step) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl.start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
endmodule

// ===== rtl/radix_calculator_accumulator.sv =====
// ----------------------------------------------------------------------------
// radix_calculator_accumulator
// command driven accumulator calculator with radix 2..36 entry and printing
// ----------------------------------------------------------------------------
// channel  dir  fields                                       transfer
// in_      in   action, digit_value, last_digit, new_radix   valid & ready
// out_     out  digit_out, last_out, error_out               valid & ready
//
// clear, op select, radix change: applied on acceptance
// operand digit: accept, then shift-add over the 6 radix bits; the last
//   digit then runs a shift-add multiply (ST_MUL) or, for div/mod, a
//   divider pass and a sign fix (ST_DIV, ST_DIV_FIX)
// equal: one divider pass per digit (shared divider), then each digit is
//   read back and printed, waiting while the output is stalled
// reset: synchronous, active low; no clearing pass, the digit ram is scratch
// in_ready is low from acceptance of a digit or equal until its work ends and the last result transfers
// ----------------------------------------------------------------------------
module radix_calculator_accumulator
  import rca_pkg::*;
#(
  parameter int unsigned ACC_WIDTH   = 64,
  parameter int unsigned DIGIT_SLOTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  rca_if.sink   in_ch,
  rca_if.source out_ch
);
  localparam int unsigned CW = $clog2(ACC_WIDTH + 1);
  localparam int unsigned SW = $clog2(DIGIT_SLOTS);
  localparam int unsigned NW = $clog2(DIGIT_SLOTS + 1);

  // input payload fields
  logic [ACTION_W-1:0] in_action;
  logic [DIGIT_W-1:0]  in_digit_value;
  logic                in_last_digit;
  logic [DIGIT_W-1:0]  in_new_radix;
  assign in_action      = in_ch.data.action;
  assign in_digit_value = in_ch.data.digit_value;
  assign in_last_digit  = in_ch.data.last_digit;
  assign in_new_radix   = in_ch.data.new_radix;

  state_t state_r, state_nxt;

  logic [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic [ACC_WIDTH-1:0] opnd_r, opnd_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [DIGIT_W-1:0]   radix_r, radix_nxt;
  logic                 err_r, err_nxt;
  logic                 last_r, last_nxt;

  // shared work registers: multiplier/multiplicand, product, step counter
  logic [ACC_WIDTH-1:0] wa_r, wa_nxt;
  logic [ACC_WIDTH-1:0] wb_r, wb_nxt;
  logic [ACC_WIDTH-1:0] wp_r, wp_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [NW-1:0]        ndig_r, ndig_nxt;
  logic                 neg_r, neg_nxt;

  // output register
  logic                 ovalid_r, ovalid_nxt;
  logic [DIGIT_W-1:0]   odig_r, odig_nxt;
  logic                 olast_r, olast_nxt;
  logic                 oerr_r, oerr_nxt;

  // digit ram
  logic               ram_we;
  logic [SW-1:0]      ram_addr;
  logic [DIGIT_W-1:0] ram_wdata, ram_rdata;

  // divider
  div_ctl_t             dctl;
  logic [ACC_WIDTH-1:0] div_a, div_b, div_q, div_rem;

  rca_ram #(.WIDTH(DIGIT_W), .DEPTH(DIGIT_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  rca_div #(.W(ACC_WIDTH)) u_div (
    .clk       (clk),
    .ctl       (dctl),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  function automatic logic [ACC_WIDTH-1:0] mag(input logic [ACC_WIDTH-1:0] v);
    mag = v[ACC_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  logic accept;
  logic out_xfer;
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  assign in_ch.ready  = (state_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = out_item_t'{digit_out: odig_r, last_out: olast_r,
                                    error_out: oerr_r};

  // one shift-add step: partial product plus shifted multiplicand
  logic [ACC_WIDTH-1:0] mac_sum;
  assign mac_sum = wp_r + (wa_r[0] ? wb_r : '0);

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    opnd_nxt   = opnd_r;
    op_nxt     = op_r;
    radix_nxt  = radix_r;
    err_nxt    = err_r;
    last_nxt   = last_r;
    wa_nxt     = wa_r;
    wb_nxt     = wb_r;
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    ndig_nxt   = ndig_r;
    neg_nxt    = neg_r;
    ovalid_nxt = ovalid_r && !out_xfer;
    odig_nxt   = odig_r;
    olast_nxt  = olast_r;
    oerr_nxt   = oerr_r;
    ram_we     = 1'b0;
    ram_addr   = ndig_r[SW-1:0];
    ram_wdata  = div_rem[DIGIT_W-1:0];
    dctl       = '0;
    div_a      = '0;
    div_b      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority case (in_action)
            ACT_CLEAR: begin
              acc_nxt  = '0;
              opnd_nxt = '0;
              err_nxt  = 1'b0;
              op_nxt   = OP_LOAD;
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
              op_nxt   = in_action[OP_W-1:0];
              opnd_nxt = '0;
            end
            ACT_RADIX: begin
              if (in_new_radix >= RADIX_MIN && in_new_radix <= RADIX_MAX) begin
                radix_nxt = in_new_radix;
              end
            end
            ACT_DIGIT: begin
              // operand*radix + digit, shift-add over the 6 radix bits
              wa_nxt    = {{(ACC_WIDTH-DIGIT_W){1'b0}}, radix_r};
              wb_nxt    = opnd_r;
              wp_nxt    = {{(ACC_WIDTH-DIGIT_W){1'b0}}, in_digit_value};
              cnt_nxt   = CW'(DIGIT_W);
              last_nxt  = in_last_digit;
              state_nxt = ST_MAC;
            end
            ACT_EQUAL: begin
              if (err_r || acc_r[ACC_WIDTH-1]) begin
                state_nxt = ST_ERR;
              end else begin
                wa_nxt    = acc_r;
                ndig_nxt  = '0;
                state_nxt = ST_CONV;
              end
            end
            default: ;
          endcase
        end
      end

      ST_MAC: begin
        wp_nxt  = mac_sum;
        wa_nxt  = wa_r >> 1;
        wb_nxt  = wb_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          opnd_nxt  = mac_sum;
          state_nxt = ST_IDLE;
          if (last_r) begin
            opnd_nxt  = '0;
            state_nxt = ST_IDLE;
            unique case (op_r)
              OP_LOAD: acc_nxt = mac_sum;
              OP_ADD:  acc_nxt = acc_r + mac_sum;
              OP_SUB:  acc_nxt = acc_r - mac_sum;
              OP_MUL: begin
                wa_nxt    = mac_sum;
                wb_nxt    = acc_r;
                wp_nxt    = '0;
                cnt_nxt   = CW'(ACC_WIDTH);
                state_nxt = ST_MUL;
              end
              OP_DIV, OP_MOD: begin
                if (mac_sum == '0) begin
                  err_nxt = 1'b1;
                end else begin
                  dctl.start = 1'b1;
                  div_a      = mag(acc_r);
                  div_b      = mag(mac_sum);
                  neg_nxt    = (op_r == OP_DIV) ?
                               (acc_r[ACC_WIDTH-1] ^ mac_sum[ACC_WIDTH-1]) :
                               acc_r[ACC_WIDTH-1];
                  cnt_nxt    = CW'(ACC_WIDTH);
                  state_nxt  = ST_DIV;
                end
              end
              default: ;
            endcase
          end
        end
      end

      ST_MUL: begin
        wp_nxt  = mac_sum;
        wa_nxt  = wa_r >> 1;
        wb_nxt  = wb_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          acc_nxt   = mac_sum;
          state_nxt = ST_IDLE;
        end
      end

      ST_DIV: begin
        dctl.step = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_DIV_FIX;
        end
      end

      ST_DIV_FIX: begin
        wp_nxt    = (op_r == OP_DIV) ? div_q : div_rem;
        acc_nxt   = neg_r ? (~wp_nxt + 1'b1) : wp_nxt;
        state_nxt = ST_IDLE;
      end

      // one digit per divider pass: wa holds the remaining value
      ST_CONV: begin
        dctl.start = 1'b1;
        div_a      = wa_r;
        div_b      = {{(ACC_WIDTH-DIGIT_W){1'b0}}, radix_r};
        cnt_nxt    = CW'(ACC_WIDTH);
        state_nxt  = ST_CONV_STORE;
      end

      ST_CONV_STORE: begin
        if (cnt_r != '0) begin
          dctl.step = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end else begin
          ram_we   = 1'b1;
          wa_nxt   = div_q;
          ndig_nxt = ndig_r + 1'b1;
          if (div_q == '0 || ndig_r == NW'(DIGIT_SLOTS - 1)) begin
            state_nxt = ST_PRINT_RD;
          end else begin
            state_nxt = ST_CONV;
          end
        end
      end

      // read the top stored digit, then hand it to the output register
      ST_PRINT_RD: begin
        ram_addr  = SW'(ndig_r - 1'b1);
        state_nxt = ST_PRINT;
      end

      ST_PRINT: begin
        ram_addr = SW'(ndig_r - 1'b1);
        if (!ovalid_r || out_xfer) begin
          ovalid_nxt = 1'b1;
          odig_nxt   = ram_rdata;
          olast_nxt  = (ndig_r == NW'(1));
          oerr_nxt   = 1'b0;
          ndig_nxt   = ndig_r - 1'b1;
          state_nxt  = (ndig_r == NW'(1)) ? ST_IDLE : ST_PRINT_RD;
        end
      end

      ST_ERR: begin
        ovalid_nxt = 1'b1;
        odig_nxt   = '0;
        olast_nxt  = 1'b1;
        oerr_nxt   = 1'b1;
        state_nxt  = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acc_r    <= '0;
      opnd_r   <= '0;
      op_r     <= OP_ADD;
      radix_r  <= RADIX_RESET;
      err_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      opnd_r   <= opnd_nxt;
      op_r     <= op_nxt;
      radix_r  <= radix_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    wa_r   <= wa_nxt;
    wb_r   <= wb_nxt;
    wp_r   <= wp_nxt;
    cnt_r  <= cnt_nxt;
    ndig_r <= ndig_nxt;
    neg_r  <= neg_nxt;
    odig_r <= odig_nxt;
    olast_r <= olast_nxt;
    oerr_r <= oerr_nxt;
  end
endmodule
